// ===== hdl/vgs_pkg.sv =====
// Package for the vacuum grip supervisor: configuration and result types,
// command codes, register indexes and reset values.
// No dependencies; used by vgs_fsm and vacuum_grip_supervisor_unit.
package vgs_pkg;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;
  localparam logic [1:0] CMD_WARMUP = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned CFG_DATA_WIDTH = 17;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_WARMUP_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LOST_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DROP_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PAIR_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RELEASE_THRESH = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ON_DUTY        = 3'd5;

  localparam logic [6:0] DUTY_MAX = 7'd100;

  typedef struct packed {
    logic [9:0]  warmup_limit;
    logic [3:0]  lost_limit;
    logic [15:0] drop_threshold;
    logic [16:0] drop_pair_threshold;
    logic [15:0] release_threshold;
    logic [6:0]  on_duty;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    warmup_limit:        10'd600,
    lost_limit:          4'd5,
    drop_threshold:      16'd4,
    drop_pair_threshold: 17'd5,
    release_threshold:   16'd1,
    on_duty:             7'd100
  };

  typedef struct packed {
    logic [2:0] mode;
    logic       mode_entered;
    logic       drive_write;
    logic [6:0] drive_duty;
  } result_t;

endpackage

// ===== hdl/vgs_fsm.sv =====
// Supervisor state machine: mode, peak count, previous drop and tick counters.
// Computes one result per step from the current item and advances its state.
// Depends on vgs_pkg.
module vgs_fsm #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  vgs_pkg::cfg_t                 cfg,
  input  logic [1:0]                    cmd,
  input  logic signed [COUNT_WIDTH-1:0] encoder_value,
  input  logic signed [15:0]            speed,
  output vgs_pkg::result_t              res
);

  // Compare width: holds the sum of two drops and every threshold as signed.
  localparam int SW = (COUNT_WIDTH + 2 > 18) ? COUNT_WIDTH + 2 : 18;

  typedef enum logic [2:0] {
    ST_OFF    = 3'd0,
    ST_WARMUP = 3'd1,
    ST_ON     = 3'd2,
    ST_SUCKED = 3'd3,
    ST_LOST   = 3'd4,
    ST_INIT   = 3'd5
  } mode_t;

  mode_t                         mode_r, mode_nxt;
  mode_t                         last_mode_r;
  logic signed [COUNT_WIDTH-1:0] peak_r, peak_nxt;
  logic signed [COUNT_WIDTH:0]   last_drop_r, last_drop_nxt;
  logic [9:0]                    warm_r, warm_nxt;
  logic [3:0]                    lost_r, lost_nxt;

  logic signed [COUNT_WIDTH:0]   drop;
  logic signed [SW-1:0]          drop_w, pair_w, th_w, pair_th_w, rel_th_w;
  logic                          still;
  logic                          keep_prev;
  logic                          entered;
  logic                          wr;
  logic [6:0]                    duty;

  // The drop is measured against the peak as it stood before this item.
  assign drop      = {peak_r[COUNT_WIDTH-1], peak_r}
                   - {encoder_value[COUNT_WIDTH-1], encoder_value};
  assign drop_w    = {{(SW-COUNT_WIDTH-1){drop[COUNT_WIDTH]}}, drop};
  assign pair_w    = drop_w + {{(SW-COUNT_WIDTH-1){last_drop_r[COUNT_WIDTH]}}, last_drop_r};
  assign th_w      = {{(SW-16){1'b0}}, cfg.drop_threshold};
  assign pair_th_w = {{(SW-17){1'b0}}, cfg.drop_pair_threshold};
  assign rel_th_w  = {{(SW-16){1'b0}}, cfg.release_threshold};
  assign still     = (speed == 16'sd0);

  always_comb begin
    mode_nxt  = mode_r;
    peak_nxt  = peak_r;
    warm_nxt  = warm_r;
    lost_nxt  = lost_r;
    keep_prev = 1'b0;
    wr        = 1'b0;
    duty      = 7'd0;

    unique case (mode_r)
      ST_WARMUP: begin
        if (cmd == vgs_pkg::CMD_START) begin
          mode_nxt  = ST_ON;
          warm_nxt  = 10'd0;
          keep_prev = 1'b1;
        end else if (cmd == vgs_pkg::CMD_STOP || warm_r > cfg.warmup_limit) begin
          mode_nxt  = ST_OFF;
          warm_nxt  = 10'd0;
          keep_prev = 1'b1;
        end
      end
      ST_OFF: begin
        if (cmd == vgs_pkg::CMD_WARMUP) begin
          mode_nxt  = ST_WARMUP;
          keep_prev = 1'b1;
        end else if (cmd == vgs_pkg::CMD_START) begin
          mode_nxt  = ST_ON;
          keep_prev = 1'b1;
        end
      end
      ST_ON: begin
        if (cmd == vgs_pkg::CMD_STOP) begin
          mode_nxt  = ST_OFF;
          keep_prev = 1'b1;
        end else begin
          if (encoder_value > peak_r) peak_nxt = encoder_value;
          if (pair_w >= pair_th_w || drop_w >= th_w) mode_nxt = ST_SUCKED;
        end
      end
      ST_SUCKED: begin
        if (cmd == vgs_pkg::CMD_STOP) mode_nxt = ST_OFF;
        else if (drop_w <= rel_th_w && still) mode_nxt = ST_LOST;
      end
      ST_LOST: begin
        if (cmd == vgs_pkg::CMD_STOP) mode_nxt = ST_OFF;
        // The counter survives a stop and is cleared only by the timeout.
        if (lost_r > cfg.lost_limit) begin
          mode_nxt = ST_OFF;
          lost_nxt = 4'd0;
        end
      end
      default: mode_nxt = ST_OFF;
    endcase

    last_drop_nxt = keep_prev ? last_drop_r : drop;
    entered       = (mode_nxt != last_mode_r);

    unique case (mode_nxt)
      ST_WARMUP: begin
        if (entered) begin
          wr   = 1'b1;
          duty = cfg.on_duty;
        end
        if (warm_nxt != 10'h3FF) warm_nxt = warm_nxt + 10'd1;
      end
      ST_OFF: begin
        if (entered) begin
          peak_nxt = '0;
          wr       = 1'b1;
        end
      end
      ST_ON: begin
        if (entered) begin
          wr   = 1'b1;
          duty = cfg.on_duty;
        end
      end
      ST_LOST: begin
        if (lost_nxt != 4'hF) lost_nxt = lost_nxt + 4'd1;
      end
      default: ;
    endcase
  end

  assign res.mode         = mode_nxt;
  assign res.mode_entered = entered;
  assign res.drive_write  = wr;
  assign res.drive_duty   = duty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ST_OFF;
      last_mode_r <= ST_INIT;
      peak_r      <= '0;
      last_drop_r <= '0;
      warm_r      <= 10'd0;
      lost_r      <= 4'd0;
    end else if (step) begin
      mode_r      <= mode_nxt;
      last_mode_r <= mode_nxt;
      peak_r      <= peak_nxt;
      last_drop_r <= last_drop_nxt;
      warm_r      <= warm_nxt;
      lost_r      <= lost_nxt;
    end
  end

  a_write_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.drive_write |-> res.mode_entered)
    else $error("pump duty written without a mode change");

  a_last_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && step |=> last_mode_r == mode_r)
    else $error("last mode does not follow mode after a step");

  a_off_clears_peak: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && step && res.mode_entered && mode_nxt == ST_OFF |=> peak_r == '0)
    else $error("peak not cleared on entering off");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !step |=> $stable(mode_r) && $stable(peak_r) && $stable(lost_r))
    else $error("supervisor state changed without an item");

  a_warm_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != ST_WARMUP |-> warm_r == 10'd0)
    else $error("warmup counter nonzero outside warmup");

endmodule

// ===== hdl/vacuum_grip_supervisor_unit.sv =====
// Top level of the vacuum grip supervisor: input register, configuration
// registers, result register and the supervisor state machine.
// Depends on vgs_pkg and vgs_fsm.
// Usage:
//   The input channel (in_valid / in_stall) carries one sensor tick per item:
//   a command, an encoder count and a speed. Each item yields exactly one
//   result item on the output channel (out_valid / out_stall): the mode after
//   the tick, whether the mode changed, and an optional pump duty write.
//   An accepted item waits in the input register; its result is loaded
//   into the result register when that register is empty or being emptied.
//   One item per cycle is taken sustained while the receiver does not stall,
//   as vgs_fsm updates its state once for each item that moves on.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; further items are stalled
//   until the result is taken.
//   Reset (synchronous, active low) empties both registers, loads the
//   configuration defaults and puts the supervisor in off, so the first
//   item always reports a mode entry.
//   Configuration must be written through cfg_we / cfg_index / cfg_wdata
//   only while no item is in flight; the unit itself does not enforce it.
module vacuum_grip_supervisor_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   cfg_we,
  input  logic [vgs_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [vgs_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_cmd,
  input  logic signed [COUNT_WIDTH-1:0]          in_encoder_value,
  input  logic signed [15:0]                     in_speed,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [2:0]                             out_mode,
  output logic                                   out_mode_entered,
  output logic                                   out_drive_write,
  output logic [6:0]                             out_drive_duty
);

  vgs_pkg::cfg_t                 cfg_r;
  logic [6:0]                    duty_wr;

  logic                          in_vld_r;
  logic [1:0]                    cmd_r;
  logic signed [COUNT_WIDTH-1:0] enc_r;
  logic signed [15:0]            speed_r;

  logic                          out_vld_r;
  vgs_pkg::result_t              res_r;
  vgs_pkg::result_t              res;

  logic                          advance;

  // Duty above the full-scale percentage is held at full scale.
  assign duty_wr = (cfg_wdata[6:0] > vgs_pkg::DUTY_MAX) ? vgs_pkg::DUTY_MAX : cfg_wdata[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= vgs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vgs_pkg::REG_WARMUP_LIMIT:   cfg_r.warmup_limit        <= cfg_wdata[9:0];
        vgs_pkg::REG_LOST_LIMIT:     cfg_r.lost_limit          <= cfg_wdata[3:0];
        vgs_pkg::REG_DROP_THRESHOLD: cfg_r.drop_threshold      <= cfg_wdata[15:0];
        vgs_pkg::REG_PAIR_THRESHOLD: cfg_r.drop_pair_threshold <= cfg_wdata[16:0];
        vgs_pkg::REG_RELEASE_THRESH: cfg_r.release_threshold   <= cfg_wdata[15:0];
        vgs_pkg::REG_ON_DUTY:        cfg_r.on_duty             <= duty_wr;
        default: ;
      endcase
    end
  end

  // An item moves on when the result register is empty or being emptied.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r   <= in_cmd;
      enc_r   <= in_encoder_value;
      speed_r <= in_speed;
    end
  end

  vgs_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .cfg           (cfg_r),
    .cmd           (cmd_r),
    .encoder_value (enc_r),
    .speed         (speed_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_mode         = res_r.mode;
  assign out_mode_entered = res_r.mode_entered;
  assign out_drive_write  = res_r.drive_write;
  assign out_drive_duty   = res_r.drive_duty;

endmodule
